FILE: rtl/ptam_pkg.sv
`timescale 1ns / 1ps

package ptam_pkg;

	// Sample and history geometry.
	localparam int SAMPLE_W   = 24;
	localparam int HIST_DEPTH = 128;
	localparam int DELAY_W    = $clog2(HIST_DEPTH);

	// Tap set: the first taps are summed, up to MAX_TAPS of them.
	localparam int MAX_TAPS       = 32;
	localparam int TAP_MIN        = 3;
	localparam int TAP_IDX_W      = $clog2(MAX_TAPS);
	localparam int TAP_CNT_W      = $clog2(MAX_TAPS + 1);
	localparam int TAPS_PER_CYCLE = 4;
	localparam int GROUPS         = MAX_TAPS / TAPS_PER_CYCLE;
	localparam int GRP_W          = $clog2(GROUPS);

	// Delay of each tap: one, two, then the primes up to the end of the history.
	localparam logic [DELAY_W-1:0] TAP_DELAY [MAX_TAPS] = '{
		7'd1,   7'd2,   7'd3,   7'd5,   7'd7,   7'd11,  7'd13,  7'd17,
		7'd19,  7'd23,  7'd29,  7'd31,  7'd37,  7'd41,  7'd43,  7'd47,
		7'd53,  7'd59,  7'd61,  7'd67,  7'd71,  7'd73,  7'd79,  7'd83,
		7'd89,  7'd97,  7'd101, 7'd103, 7'd107, 7'd109, 7'd113, 7'd127
	};

	// Tap sum: the current sample plus up to MAX_TAPS delayed samples.
	localparam int ACC_W = SAMPLE_W + $clog2(MAX_TAPS + 1) + 1;
	localparam int MAG_W = ACC_W - 1;

	// Sequential divider sizes.
	localparam int REM_W     = $clog2(MAX_TAPS);
	localparam int DIV_CNT_W = $clog2(MAG_W);

	// Averaged term after the increment, and the Q15 mixing datapath.
	localparam int   Q_W        = SAMPLE_W + 1;
	localparam int   GAIN_W     = 16;
	localparam int   Q15_SHIFT  = 15;
	localparam logic [GAIN_W-1:0] Q15_ONE = GAIN_W'(1 << Q15_SHIFT);
	localparam int   PROD_W     = Q_W + GAIN_W + 1;
	localparam int   SUM_W      = PROD_W + 2;
	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (Q15_SHIFT - 1));

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = GAIN_W;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBTRACT_MODE = 2'd2;

	localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = TAP_CNT_W'(8);
	localparam logic [GAIN_W-1:0]    WET_GAIN_RESET  = GAIN_W'(16384);

endpackage

FILE: rtl/ptam_cell.sv
`timescale 1ns / 1ps

module ptam_cell
	import ptam_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift_en,
	input  logic signed [SAMPLE_W-1:0] sample_d,
	output logic signed [SAMPLE_W-1:0] sample_q
);

	// One history slot: takes its neighbour's sample on every accepted transfer.
	logic signed [SAMPLE_W-1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift_en) begin
			slot_q <= sample_d;
		end
	end

	assign sample_q = slot_q;

endmodule

FILE: rtl/ptam_div.sv
`timescale 1ns / 1ps

module ptam_div
	import ptam_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MAG_W-1:0]     dividend,
	input  logic [TAP_CNT_W-1:0] divisor,
	output logic [MAG_W-1:0]     quotient,
	output logic                 done
);

	logic [MAG_W-1:0]     dvd_q;
	logic [REM_W-1:0]     rem_q;
	logic [TAP_CNT_W-1:0] dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic           fits;

	// Restoring step: bring down the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, dvd_q[MAG_W-1]};
		fits  = ((REM_W + 1)'(dsr_q) <= trial);
		diff  = trial - (REM_W + 1)'(dsr_q);
	end

	// One quotient bit per cycle; quotient bits shift in behind the dividend.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(MAG_W - 1);
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[MAG_W-2:0], fits};
				rem_q <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

FILE: rtl/prime_tap_average_mixer_unit.sv
`timescale 1ns / 1ps

// Sparse-tap moving average mixed with the dry signal, one audio sample at a time.
// Input channel: in_valid, in_stall and sample_in; a transfer happens at a clock edge
// with in_valid high and in_stall low. Output channel: out_valid, out_stall and
// sample_out, with the same rule; the block drives in_stall and out_valid.
// Configuration: cfg_valid, cfg_ready, cfg_index and cfg_data; cfg_ready is always
// high. Index 0 is the tap count, 1 the Q15 wet gain, 2 the subtract mode; other
// indexes are ignored. Write configuration only while the block is idle.
// Each sample passes through a row of 128 history cells; the sum over the chosen
// taps is accumulated four taps a cycle, divided by a radix-2 divider and mixed
// through one shared multiplier. A new sample is taken only once the last one has
// left the sequencer; in_stall is high in every state but idle.
// The output register holds a finished sample while out_stall is high, and a new
// sample is already accepted meanwhile; the next result waits until it is taken.
// Reset clears the history to zero and loads tap count 8, wet gain 16384 and
// crossfade mode; the block accepts input in the first cycle after reset.
module prime_tap_average_mixer_unit
	import ptam_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_START,
		ST_DIVIDE,
		ST_MUL_DRY,
		ST_MUL_WET,
		ST_ROUND
	} state_t;

	state_t state_q;

	logic [TAP_CNT_W-1:0] tap_count_q;
	logic [GAIN_W-1:0]    wet_gain_q;
	logic                 subtract_mode_q;

	logic signed [SAMPLE_W-1:0] hist [HIST_DEPTH];
	logic signed [SAMPLE_W-1:0] tap_val [MAX_TAPS];

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [GRP_W-1:0]           grp_q;
	logic                       neg_q;
	logic signed [Q_W-1:0]      q_q;
	logic signed [PROD_W-1:0]   pdry_q;
	logic signed [PROD_W-1:0]   pwet_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	logic                       in_xfer;
	logic [TAP_CNT_W-1:0]       taps;
	logic [GAIN_W-1:0]          wet_c;
	logic [GAIN_W-1:0]          dry_coef;
	logic signed [ACC_W-1:0]    grp_sum;
	logic signed [ACC_W-1:0]    abs_acc;
	logic                       div_start;
	logic [MAG_W-1:0]           quo;
	logic                       div_done;
	logic signed [ACC_W-1:0]    quo_s;
	logic signed [ACC_W-1:0]    q_next;
	logic signed [Q_W-1:0]      mul_a;
	logic signed [GAIN_W:0]     mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [SUM_W-1:0]    mix;
	logic signed [SUM_W-1:0]    shifted;
	logic signed [SAMPLE_W-1:0] y;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q     <= TAP_COUNT_RESET;
			wet_gain_q      <= WET_GAIN_RESET;
			subtract_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TAP_COUNT:     tap_count_q     <= cfg_data[TAP_CNT_W-1:0];
				CFG_WET_GAIN:      wet_gain_q      <= cfg_data;
				CFG_SUBTRACT_MODE: subtract_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the tap count and the wet gain to their useful ranges.
	always_comb begin
		if (tap_count_q < TAP_CNT_W'(TAP_MIN)) begin
			taps = TAP_CNT_W'(TAP_MIN);
		end else if (tap_count_q > TAP_CNT_W'(MAX_TAPS)) begin
			taps = TAP_CNT_W'(MAX_TAPS);
		end else begin
			taps = tap_count_q;
		end
		wet_c    = (wet_gain_q > Q15_ONE) ? Q15_ONE : wet_gain_q;
		dry_coef = subtract_mode_q ? Q15_ONE : (Q15_ONE - wet_c);
	end

	// History: a row of cells, the newest sample in the first cell.
	for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_hist
		if (i == 0) begin : g_head
			ptam_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (in_xfer),
				.sample_d (sample_in),
				.sample_q (hist[i])
			);
		end else begin : g_body
			ptam_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (in_xfer),
				.sample_d (hist[i-1]),
				.sample_q (hist[i])
			);
		end
	end

	// Fixed tap points along the row.
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
		assign tap_val[k] = hist[TAP_DELAY[k]];
	end

	// Add one group of taps to the running sum, skipping taps beyond the count.
	always_comb begin
		logic [TAP_IDX_W-1:0] k;
		grp_sum = acc_q;
		for (int j = 0; j < TAPS_PER_CYCLE; j++) begin
			k = TAP_IDX_W'(int'(grp_q) * TAPS_PER_CYCLE + j);
			if (TAP_CNT_W'(k) < taps) begin
				grp_sum = grp_sum + ACC_W'(tap_val[k]);
			end
		end
	end

	// Magnitude of the sum goes to the divider; the sign is restored afterwards.
	assign abs_acc   = acc_q[ACC_W-1] ? -acc_q : acc_q;
	assign div_start = (state_q == ST_START);

	ptam_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (abs_acc[MAG_W-1:0]),
		.divisor  (taps),
		.quotient (quo),
		.done     (div_done)
	);

	always_comb begin
		quo_s  = neg_q ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
		q_next = quo_s + ACC_W'(1);
	end

	// Shared multiplier: dry product first, then the wet product.
	always_comb begin
		if (state_q == ST_MUL_WET) begin
			mul_a = q_q;
			mul_b = signed'({1'b0, wet_c});
		end else begin
			mul_a = Q_W'(x_q);
			mul_b = signed'({1'b0, dry_coef});
		end
	end
	assign prod = mul_a * mul_b;

	// Combine, round half up in Q15 and saturate to the sample range.
	always_comb begin
		if (subtract_mode_q) begin
			mix = SUM_W'(pdry_q) - SUM_W'(pwet_q);
		end else begin
			mix = SUM_W'(pdry_q) + SUM_W'(pwet_q);
		end
		shifted = (mix + signed'(ROUND_HALF)) >>> Q15_SHIFT;
		if ((&shifted[SUM_W-1:SAMPLE_W-1]) || !(|shifted[SUM_W-1:SAMPLE_W-1])) begin
			y = shifted[SAMPLE_W-1:0];
		end else if (shifted[SUM_W-1]) begin
			y = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			y = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			grp_q       <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (state_q == ST_ROUND && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						x_q     <= sample_in;
						acc_q   <= ACC_W'(sample_in);
						grp_q   <= '0;
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					acc_q <= grp_sum;
					grp_q <= grp_q + 1'b1;
					if (grp_q == GRP_W'(GROUPS - 1)) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					neg_q   <= acc_q[ACC_W-1];
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_done) begin
						q_q     <= q_next[Q_W-1:0];
						state_q <= ST_MUL_DRY;
					end
				end
				ST_MUL_DRY: begin
					pdry_q  <= prod;
					state_q <= ST_MUL_WET;
				end
				ST_MUL_WET: begin
					pwet_q  <= prod;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (!out_valid_q || !out_stall) begin
						sample_out_q <= y;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

FILE: tb/tb_prime_tap_average_mixer_unit.sv
`timescale 1ns / 1ps

module tb_prime_tap_average_mixer_unit;

	localparam int SW = ptam_pkg::SAMPLE_W;
	localparam int HIST = 128;
	localparam int TAP_FLOOR = 3;
	localparam int TAP_CEIL = 32;
	localparam longint UNITY = 32768;
	localparam longint HALF_LSB = 16384;
	localparam int Q15_BITS = 15;
	localparam longint OUT_HI = 8388607;
	localparam longint OUT_LO = -8388608;
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [ptam_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	localparam int IDLE_PCT = 9;
	localparam int HOLD_CYCLES = 400;
	localparam int REPORT_MAX = 10;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 148;
	localparam int CHUNK_ITEMS = 24;

	// Shapes of random sample streams.
	localparam int STYLE_FULL = 0;
	localparam int STYLE_NEAR_RAIL = 1;
	localparam int STYLE_QUIET = 2;
	localparam int STYLE_RAILS = 3;

	// Predicts the mixed output of every accepted sample and checks the
	// results in order against those predictions.
	class mix_predictor;
		logic signed [SW-1:0] history [HIST];
		logic [6:0] wr_pos;
		logic [5:0] tap_count;
		logic [15:0] wet_gain;
		logic subtract_mode;
		int unsigned tap_delay [32];
		logic signed [SW-1:0] expected_mix [$];
		int errors;

		function new();
			foreach (history[i]) history[i] = '0;
			wr_pos = '0;
			tap_count = 6'd8;
			wet_gain = 16'd16384;
			subtract_mode = 1'b0;
			tap_delay = '{1, 2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
				53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127};
			errors = 0;
		endfunction

		// A write to an unused index leaves every register alone.
		function void write_reg(logic [ptam_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				ptam_pkg::CFG_TAP_COUNT: tap_count = data[5:0];
				ptam_pkg::CFG_WET_GAIN: wet_gain = data;
				ptam_pkg::CFG_SUBTRACT_MODE: subtract_mode = data[0];
				default: ;
			endcase
		endfunction

		function void take_sample(logic signed [SW-1:0] x);
			int unsigned taps;
			longint wet, total, avg, acc, y;
			logic [6:0] idx;
			int k;
			taps = tap_count;
			if (taps < TAP_FLOOR) taps = TAP_FLOOR;
			if (taps > TAP_CEIL) taps = TAP_CEIL;
			wet = wet_gain;
			if (wet > UNITY) wet = UNITY;

			// The new sample goes into the ring before the taps are read.
			history[wr_pos] = x;
			total = x;
			for (k = 0; k < taps; k++) begin
				idx = wr_pos - 7'(tap_delay[k]);
				total += history[idx];
			end
			wr_pos = wr_pos + 7'd1;

			// Division truncates toward zero, then the average is nudged up by one.
			avg = total / longint'(taps) + 1;
			if (subtract_mode)
				acc = longint'(x) * UNITY - avg * wet;
			else
				acc = longint'(x) * (UNITY - wet) + avg * wet;

			// Round half up in Q15, then clip to the sample range.
			y = (acc + HALF_LSB) >>> Q15_BITS;
			if (y > OUT_HI) y = OUT_HI;
			if (y < OUT_LO) y = OUT_LO;
			expected_mix.push_back(y[SW-1:0]);
		endfunction

		function void check_mix(logic signed [SW-1:0] got);
			logic signed [SW-1:0] want;
			if (expected_mix.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("sample_out %0d arrived with nothing pending", got);
			end else begin
				want = expected_mix.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("sample_out mismatch: expected %0d, got %0d", want, got);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SW-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SW-1:0] sample_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ptam_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ptam_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic calm = 1'b0;
	logic hold_tog = 1'b0;
	logic hold_ack;
	int hold_left;
	int cycles = 0;
	mix_predictor mix;

	prime_tap_average_mixer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Timeout guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Output side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_ack <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_tog != hold_ack) begin
			hold_ack <= hold_tog;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Watch every transfer on the three channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) mix.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) mix.take_sample(sample_in);
			if (out_valid && !out_stall) mix.check_mix(sample_out);
		end
	end

	// Offer one sample, idling now and then beforehand; returns at its transfer.
	task automatic send_sample(input logic signed [SW-1:0] x);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Leaves cfg_valid high so that writes can follow back to back.
	task automatic write_cfg(input logic [ptam_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	// One edge first, so that the last input transfer is already noted.
	task automatic wait_drain();
		@(posedge clk);
		while (mix.expected_mix.size() != 0) @(posedge clk);
	endtask

	// Reconfigure once the block has delivered everything it owes.
	task automatic set_mode(input logic [15:0] taps, input logic [15:0] wet, input bit sub,
		input bit spare);
		in_valid <= 1'b0;
		wait_drain();
		write_cfg(ptam_pkg::CFG_TAP_COUNT, taps);
		write_cfg(ptam_pkg::CFG_WET_GAIN, wet);
		write_cfg(ptam_pkg::CFG_SUBTRACT_MODE, {15'($urandom), sub});
		if (spare) write_cfg(CFG_SPARE_IDX, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SW-1:0] pick_sample(int style, bit neg);
		logic signed [SW-1:0] v;
		case (style)
			STYLE_NEAR_RAIL: v = neg ? SAMPLE_MIN + SW'($urandom_range(0, 4095))
				: SAMPLE_MAX - SW'($urandom_range(0, 4095));
			STYLE_QUIET: v = SW'($urandom_range(0, 511)) - SW'(256);
			STYLE_RAILS: v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			default: v = SW'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_taps();
		logic [15:0] choices [7];
		choices = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd32, 16'd33, 16'd63};
		if ($urandom_range(0, 2) == 0) return choices[$urandom_range(0, 6)];
		return 16'($urandom_range(TAP_FLOOR, TAP_CEIL));
	endfunction

	function automatic logic [15:0] pick_wet();
		logic [15:0] choices [6];
		choices = '{16'd0, 16'd1, 16'd32767, 16'd32768, 16'd32769, 16'd65535};
		if ($urandom_range(0, 2) == 0) return choices[$urandom_range(0, 5)];
		if ($urandom_range(0, 3) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 32768));
	endfunction

	initial begin
		int p, n, style;
		bit neg;
		mix = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: rails, zero, tiny values and bit patterns.
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample('0);
		send_sample(-24'sd1);
		send_sample(24'sd1);
		send_sample(24'sh555555);
		send_sample(24'shAAAAAA);

		// Tap count of zero, full wet, subtract: both rails clip.
		set_mode(16'd0, 16'd32768, 1'b1, 1'b0);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);

		// Tap count above the range and wet gain above one.
		set_mode(16'd63, 16'hFFFF, 1'b0, 1'b0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(24'sd12345);
		send_sample(-24'sd12345);

		// Fully dry, tap count just under the floor, and a write to an unused index.
		set_mode(16'd2, 16'd0, 1'b0, 1'b1);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(24'sd7);
		send_sample(-24'sd7);

		// Random phases; the first and last pin the extremes of the settings.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				set_mode(16'd32, 16'd32768, 1'b0, 1'b1);
			else if (p == RANDOM_PHASES - 1)
				set_mode(16'd3, 16'd0, 1'b1, 1'b1);
			else
				set_mode(pick_taps(), pick_wet(), $urandom_range(0, 1),
					$urandom_range(0, 3) == 0);
			calm <= (p == 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % CHUNK_ITEMS == 0) begin
					style = $urandom_range(0, 9) < 5 ? STYLE_FULL : $urandom_range(1, 3);
					neg = $urandom_range(0, 1);
				end
				if (p == 5 && n == 20) hold_tog <= ~hold_tog;
				send_sample(pick_sample(style, neg));
			end
		end
		in_valid <= 1'b0;
		calm <= 1'b0;

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mix.errors == 0 && mix.expected_mix.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
rtl/ptam_pkg.sv
rtl/ptam_cell.sv
rtl/ptam_div.sv
rtl/prime_tap_average_mixer_unit.sv
tb/tb_prime_tap_average_mixer_unit.sv
